### rtl/sofla_pkg.sv
package sofla_pkg;

	// default geometry
	localparam longint unsigned DEF_REGION_BYTES = 64'd65536;
	localparam int DEF_NUM_CLASSES = 3;

	// configuration port
	localparam int NUM_REGS = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 64;

	// result status codes
	localparam logic [1:0] STAT_SERVED = 2'd0;
	localparam logic [1:0] STAT_PASS = 2'd1;
	localparam logic [1:0] STAT_EXHAUSTED = 2'd2;

	typedef struct packed {
		logic [63:0] addr;
		logic [1:0] status;
		logic [1:0] cls;
	} res_t;

endpackage

### rtl/small_object_free_list_allocator.sv
// Segregated free-list allocator for small blocks, one size class per 4 bytes.
// Input channel (in_valid/in_stall): command, request_size, block_address.
// Output channel (out_valid/out_stall): granted_address, status, size_class;
// exactly one result word per input word, in order.
// Config port: cfg_we writes cfg_data to the region base selected by
// cfg_index (0, 1, 2); other indexes are dropped. Write only when idle.
// Timing: when a word is accepted the link store is read at the same edge,
// and the result is registered at the next edge, into the output register or,
// if that is still occupied, the holding register. Input stalls while a word
// executes, so a new word is taken only after the previous one has finished.
// A finished result sits in the output register; while it waits the next
// word is still accepted. If a second result finishes before the first is
// taken it parks in a holding register and input stalls until it moves out.
// Reset: heads and bases go to zero, then the link memory is swept to zero,
// one entry a cycle, over all 2**(CLS_W+IDX_W) entries (65536 with the
// defaults). in_stall is high during the sweep; config writes are taken as usual.
module small_object_free_list_allocator
	import sofla_pkg::*;
#(
	parameter longint unsigned REGION_BYTES = DEF_REGION_BYTES,
	parameter int NUM_CLASSES = DEF_NUM_CLASSES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic command,
	input  logic [31:0] request_size,
	input  logic [63:0] block_address,
	output logic out_valid,
	input  logic out_stall,
	output logic [63:0] granted_address,
	output logic [1:0] status,
	output logic [1:0] size_class,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam longint unsigned REGION_WORDS = REGION_BYTES / 4;
	localparam int IDX_W = $clog2(REGION_WORDS);
	localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int LINK_W = IDX_W + 1;
	localparam int MEM_AW = CLS_W + IDX_W;
	localparam int MEM_DEPTH = 1 << MEM_AW;
	localparam logic [31:0] MAX_SIZE = 32'(4 * NUM_CLASSES);
	localparam logic [IDX_W:0] RW_X = (IDX_W + 1)'(REGION_WORDS);
	localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(REGION_WORDS - 1);
	localparam logic [63:0] RB_X = 64'(REGION_BYTES);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;
	localparam logic [1:0] ST_WAIT = 2'd3;

	localparam logic [1:0] K_PASS = 2'd0;
	localparam logic [1:0] K_ALLOC = 2'd1;
	localparam logic [1:0] K_FREE = 2'd2;

	logic [1:0] state_q;
	logic [MEM_AW-1:0] clr_q;
	logic [63:0] base_q [NUM_CLASSES];
	logic [IDX_W-1:0] head_q [NUM_CLASSES];

	logic [LINK_W-1:0] link_mem [MEM_DEPTH];
	logic [LINK_W-1:0] link_s1;

	logic [1:0] kind_s1;
	logic [CLS_W-1:0] cls_s1;
	logic [IDX_W-1:0] head_s1;
	logic [IDX_W-1:0] word_s1;
	logic [63:0] grant_s1;

	logic out_valid_q;
	res_t out_q;
	res_t pend_q;

	// accept-side decode
	logic accept;
	logic alloc_ok;
	logic [CLS_W:0] units_in;
	logic [CLS_W-1:0] alloc_cls;
	logic [63:0] diff [NUM_CLASSES];
	logic [NUM_CLASSES-1:0] hit;
	logic free_hit;
	logic [CLS_W-1:0] free_cls;
	logic [63:0] free_diff;
	logic [IDX_W:0] word_raw;
	logic [IDX_W-1:0] free_word;
	logic [1:0] kind_in;
	logic [CLS_W-1:0] sel_cls;
	logic [IDX_W-1:0] head_sel;
	logic [63:0] base_sel;

	// execute-side
	logic exec;
	logic [IDX_W:0] bump_sum;
	logic [1:0] cls_code;
	res_t res;
	logic head_we;
	logic [IDX_W-1:0] head_wd;
	logic mem_we;
	logic [MEM_AW-1:0] mem_wa;
	logic [LINK_W-1:0] mem_wd;
	logic out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign exec = (state_q == ST_EXEC);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		alloc_ok = (request_size != 32'd0) && (request_size[1:0] == 2'b00)
			&& (request_size <= MAX_SIZE);
		units_in = request_size[CLS_W+2:2];
		alloc_cls = CLS_W'(units_in - (CLS_W + 1)'(1));

		for (int c = 0; c < NUM_CLASSES; c++) begin
			diff[c] = block_address - base_q[c];
			hit[c] = (block_address >= base_q[c]) && (diff[c] < RB_X);
		end

		// lowest class wins: scan downward so it is written last
		free_hit = 1'b0;
		free_cls = '0;
		free_diff = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (hit[c]) begin
				free_hit = 1'b1;
				free_cls = CLS_W'(c);
				free_diff = diff[c];
			end
		end
		free_hit = free_hit && (block_address != 64'd0);

		// a region size that is not a multiple of 4 can put the last bytes past the last word
		word_raw = free_diff[IDX_W+2:2];
		free_word = (word_raw >= RW_X) ? LAST_WORD : word_raw[IDX_W-1:0];

		if (command) begin
			kind_in = free_hit ? K_FREE : K_PASS;
		end else begin
			kind_in = alloc_ok ? K_ALLOC : K_PASS;
		end
		sel_cls = command ? free_cls : alloc_cls;
		head_sel = head_q[sel_cls];
		base_sel = base_q[sel_cls];
	end

	always_comb begin
		bump_sum = (IDX_W + 1)'(head_s1) + (IDX_W + 1)'(cls_s1) + (IDX_W + 1)'(1);
		cls_code = 2'((CLS_W + 1)'(cls_s1) + (CLS_W + 1)'(1));
		res.addr = 64'd0;
		res.status = STAT_PASS;
		res.cls = 2'd0;
		head_we = 1'b0;
		head_wd = head_s1;
		unique case (kind_s1)
			K_ALLOC: begin
				res.cls = cls_code;
				if (link_s1[IDX_W]) begin
					head_we = 1'b1;
					head_wd = link_s1[IDX_W-1:0];
					res.addr = grant_s1;
					res.status = STAT_SERVED;
				end else if (bump_sum >= RW_X) begin
					res.status = STAT_EXHAUSTED;
				end else begin
					head_we = 1'b1;
					head_wd = bump_sum[IDX_W-1:0];
					res.addr = grant_s1;
					res.status = STAT_SERVED;
				end
			end
			K_FREE: begin
				head_we = 1'b1;
				head_wd = word_s1;
				res.status = STAT_SERVED;
				res.cls = cls_code;
			end
			default: begin
				res.status = STAT_PASS;
			end
		endcase
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else begin
			mem_we = exec && (kind_s1 == K_FREE);
			mem_wa = {cls_s1, word_s1};
			mem_wd = {1'b1, head_s1};
		end
	end

	// link store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_wa] <= mem_wd;
		end
		if (accept) begin
			link_s1 <= link_mem[{sel_cls, head_sel}];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind_in;
			cls_s1 <= sel_cls;
			head_s1 <= head_sel;
			word_s1 <= free_word;
			grant_s1 <= base_sel + 64'({head_sel, 2'b00});
		end
		if (exec && out_free) begin
			out_q <= res;
		end else if (exec) begin
			pend_q <= res;
		end else if (state_q == ST_WAIT && out_free) begin
			out_q <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				base_q[c] <= '0;
				head_q[c] <= '0;
			end
		end else begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				if (cfg_we && (int'(cfg_index) == c) && (c < NUM_REGS)) begin
					base_q[c] <= cfg_data;
				end
			end
			if (exec && head_we) begin
				head_q[cls_s1] <= head_wd;
			end
			if ((exec || state_q == ST_WAIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + MEM_AW'(1);
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign granted_address = out_q.addr;
	assign status = out_q.status;
	assign size_class = out_q.cls;

`ifndef NO_ASSERTIONS
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("accepted word did not move to execute");

	a_exh_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_EXHAUSTED) |-> (granted_address == 64'd0))
		else $error("exhausted result carries an address");

	a_pass_none: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_PASS) |-> (size_class == 2'd0 && granted_address == 64'd0))
		else $error("pass-through result carries a class or address");

	for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_head_chk
		a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
			((IDX_W + 1)'(head_q[g]) < RW_X))
			else $error("head index beyond region");
	end
`endif

endmodule

### bench/alloc_checker.sv
`timescale 1ns / 1ps

module alloc_checker
	import sofla_pkg::*;
#(
	parameter bit FREE_CODE = 1'b1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic command,
	input  logic [31:0] request_size,
	input  logic [63:0] block_address,
	input  logic out_valid,
	input  logic out_stall,
	input  logic [63:0] granted_address,
	input  logic [1:0] status,
	input  logic [1:0] size_class,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int errors,
	output int backlog
);

	localparam longint unsigned REGION_BYTES = DEF_REGION_BYTES;
	localparam int NCLS = DEF_NUM_CLASSES;
	localparam int WORDS = int'(REGION_BYTES / 4);

	// everything starts from the reset state: zero bases, heads and links
	logic [63:0] region_base [NCLS] = '{default: '0};
	logic [13:0] head_word [NCLS] = '{default: '0};
	bit link_set [NCLS][WORDS];
	logic [13:0] link_next [NCLS][WORDS] = '{default: '0};
	res_t pending_grants [$];

	task automatic flag(input string what);
		errors++;
		$display("%0t ns: %s", $time, what);
	endtask

	// one request against the free lists; returns the result word it causes
	task automatic serve(input logic cmd, input logic [31:0] sz, input logic [63:0] ad,
			output res_t r);
		int c;
		int units;
		logic [13:0] h;
		logic [63:0] off;
		bit hit;
		r.addr = '0;
		r.status = STAT_PASS;
		r.cls = '0;
		hit = 1'b0;
		if (cmd == FREE_CODE) begin
			if (ad != '0)
				for (c = 0; c < NCLS; c++) begin
					off = ad - region_base[c];
					if (!hit && ad >= region_base[c] && off < REGION_BYTES) begin
						h = 14'(off >> 2);
						link_set[c][h] = 1'b1;
						link_next[c][h] = head_word[c];
						head_word[c] = h;
						r.status = STAT_SERVED;
						r.cls = 2'(c + 1);
						hit = 1'b1;
					end
				end
		end else if (sz != '0 && sz[1:0] == 2'b00 && sz <= 4 * NCLS) begin
			units = int'(sz >> 2);
			c = units - 1;
			h = head_word[c];
			r.cls = 2'(c + 1);
			// bump past the region end leaves everything as it was
			if (!link_set[c][h] && int'(h) + units >= WORDS) begin
				r.status = STAT_EXHAUSTED;
			end else begin
				r.addr = region_base[c] + 64'(h) * 4;
				r.status = STAT_SERVED;
				head_word[c] = link_set[c][h] ? link_next[c][h] : h + 14'(units);
			end
		end
	endtask

	always @(posedge clk) begin : watch
		res_t want;
		if (arst_n) begin
			if (cfg_we && cfg_index < NUM_REGS)
				region_base[cfg_index] = cfg_data;
			if (in_valid && !in_stall) begin
				serve(command, request_size, block_address, want);
				pending_grants.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (pending_grants.size() == 0) begin
					flag($sformatf("unexpected word: addr %h status %0d class %0d",
						granted_address, status, size_class));
				end else begin
					want = pending_grants.pop_front();
					if (granted_address !== want.addr)
						flag($sformatf("granted_address %h, expected %h",
							granted_address, want.addr));
					if (status !== want.status)
						flag($sformatf("status %0d, expected %0d", status, want.status));
					if (size_class !== want.cls)
						flag($sformatf("size_class %0d, expected %0d", size_class, want.cls));
				end
			end
			backlog <= pending_grants.size();
		end
	end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import sofla_pkg::*;

	localparam bit CMD_ALLOC = 1'b0;
	localparam bit CMD_FREE = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_CLASS4_BASE = 0;
	localparam logic [CFG_IDX_W-1:0] REG_CLASS8_BASE = 1;
	localparam logic [CFG_IDX_W-1:0] REG_CLASS12_BASE = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3;
	localparam longint unsigned REGION_BYTES = DEF_REGION_BYTES;
	localparam int WORDS = int'(REGION_BYTES / 4);
	// the post-reset link sweep alone keeps the input stalled
	localparam int QUIET_LIMIT = 262144;
	localparam int PHASE_ITEMS = 315;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic command;
	logic [31:0] request_size;
	logic [63:0] block_address;
	logic out_valid;
	logic out_stall;
	logic [63:0] granted_address;
	logic [1:0] status;
	logic [1:0] size_class;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int errors;
	int backlog;
	int unsigned src_idle_max;
	int unsigned sink_idle_max;
	logic [63:0] base_of [3];

	small_object_free_list_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.request_size(request_size),
		.block_address(block_address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.granted_address(granted_address),
		.status(status),
		.size_class(size_class),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	alloc_checker #(.FREE_CODE(CMD_FREE)) chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.request_size(request_size),
		.block_address(block_address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.granted_address(granted_address),
		.status(status),
		.size_class(size_class),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.backlog(backlog)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// send one word; valid stays high afterwards until the next call decides
	task automatic push_word(input logic cmd, input logic [31:0] sz, input logic [63:0] ad);
		int unsigned idle;
		idle = $urandom_range(0, src_idle_max);
		if (idle > 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		request_size <= sz;
		block_address <= ad;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic alloc_req(input logic [31:0] sz);
		push_word(CMD_ALLOC, sz, {$urandom, $urandom});
	endtask

	task automatic free_req(input logic [63:0] ad);
		push_word(CMD_FREE, $urandom, ad);
	endtask

	task automatic program_bases(input logic [63:0] b4, input logic [63:0] b8,
			input logic [63:0] b12);
		base_of[0] = b4;
		base_of[1] = b8;
		base_of[2] = b12;
		cfg_we <= 1'b1;
		cfg_index <= REG_CLASS4_BASE;
		cfg_data <= b4;
		@(posedge clk);
		cfg_index <= REG_CLASS8_BASE;
		cfg_data <= b8;
		@(posedge clk);
		cfg_index <= REG_CLASS12_BASE;
		cfg_data <= b12;
		@(posedge clk);
		// no register behind this index; must be dropped
		cfg_index <= REG_SPARE;
		cfg_data <= {$urandom, $urandom};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (backlog != 0);
	endtask

	task automatic random_request();
		int pick;
		int c;
		int w;
		logic [63:0] a;
		logic [31:0] s;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			alloc_req(32'(4 * $urandom_range(1, 3)));
		end else if (pick < 55) begin
			case ($urandom_range(0, 4))
				0: s = '0;
				1: s = $urandom;
				2: s = 32'($urandom_range(13, 64));
				3: s = $urandom | 32'($urandom_range(1, 3));
				default: s = 32'hFFFF_FFFC;
			endcase
			alloc_req(s);
		end else if (pick < 88) begin
			// block inside a region, often near its end, low bits random
			c = $urandom_range(0, 2);
			if ($urandom_range(0, 3) == 0)
				w = $urandom_range(WORDS - 8, WORDS - 1);
			else
				w = $urandom_range(0, WORDS - 1);
			a = base_of[c] + 64'(w) * 4 + 64'($urandom_range(0, 3));
			free_req(a);
		end else begin
			case ($urandom_range(0, 3))
				0: a = '0;
				1: a = {$urandom, $urandom};
				2: a = base_of[$urandom_range(0, 2)] - 1;
				default: a = base_of[$urandom_range(0, 2)] + REGION_BYTES;
			endcase
			free_req(a);
		end
	endtask

	// result side: random hold-off before each word is taken
	initial begin : sink
		int unsigned hold;
		out_stall <= 1'b1;
		@(posedge clk);
		forever begin
			hold = $urandom_range(0, sink_idle_max);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [63:0] b;
		src_idle_max = 0;
		sink_idle_max = 0;
		base_of[0] = '0;
		base_of[1] = '0;
		base_of[2] = '0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_ALLOC;
		request_size <= '0;
		block_address <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_CLASS4_BASE;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// corner cases, all bases still zero so the regions overlap
		src_idle_max = 3;
		sink_idle_max = 3;
		alloc_req(32'd4);
		alloc_req(32'd8);
		alloc_req(32'd12);
		alloc_req(32'd0);
		alloc_req(32'd1);
		alloc_req(32'd2);
		alloc_req(32'd3);
		alloc_req(32'd13);
		alloc_req(32'd16);
		alloc_req(32'hFFFF_FFFF);
		alloc_req(32'hFFFF_FFFC);
		alloc_req(32'h8000_0008);
		free_req(64'd0);
		free_req(64'hFFFF_FFFF_FFFF_FFFF);
		free_req(64'd65536);
		free_req(64'd65535);
		free_req(64'd1);
		alloc_req(32'd4);
		alloc_req(32'd4);
		alloc_req(32'd4);
		alloc_req(32'd8);
		free_req(64'd40);
		alloc_req(32'd8);
		alloc_req(32'd4);
		drain();

		for (int p = 0; p < 6; p++) begin
			b = {$urandom, $urandom} & ~64'h3;
			case (p)
				0: begin
					program_bases(b, {$urandom, $urandom} & ~64'h3,
						{$urandom, $urandom} & ~64'h3);
					src_idle_max = 17;
					sink_idle_max = 17;
				end
				1: begin
					program_bases(b, b + REGION_BYTES, b + 2 * REGION_BYTES);
					src_idle_max = 0;
					sink_idle_max = 0;
				end
				2: begin
					program_bases(64'hFFFF_FFFF_FFFF_FFFC, 64'hFFFF_FFFF_0000_0000,
						64'hFFFF_FFFF_FFFF_FFFF);
					src_idle_max = 0;
					sink_idle_max = 17;
				end
				3: begin
					program_bases(64'h0000_0000_FFFF_FFFF, 64'd0, 64'hFFFF_FFFF_FFFF_0000);
					src_idle_max = 17;
					sink_idle_max = 0;
				end
				4: begin
					program_bases(b, b, b);
					src_idle_max = 17;
					sink_idle_max = 17;
				end
				default: begin
					program_bases(64'd4, 64'd65536, 64'd131072);
					src_idle_max = 17;
					sink_idle_max = 17;
				end
			endcase
			repeat (PHASE_ITEMS) random_request();
			drain();
		end

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
